// ===== rtl/pmc_pkg.sv =====
// shared constants, register indexes and types of the position pi motor controller
package pmc_pkg;

  // field widths of the channel beats
  localparam int DeltaW = 16;
  localparam int CmdW   = 8;
  localparam int SpeedW = 8;
  localparam int TposW  = 13;

  // configuration port
  localparam int GainW   = 8;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegPropGain = 2'd0;
  localparam logic [CfgIdxW-1:0] RegIntGain  = 2'd1;

  localparam logic [GainW-1:0] GainReset = 8'd3;

  // setpoint scale and error scale (both 32), output scale (64)
  localparam int SetShift = 5;
  localparam int CtlShift = 6;

  // speed saturation level
  localparam int SpeedMax = 255;

  // pipeline control handed to the control-law stages
  typedef struct packed {
    logic adv;  // every stage moves forward
    logic vld;  // first stage holds a live beat
  } pmc_ctl_t;

endpackage

// ===== rtl/pmc_if.sv =====
// valid/ready channel interfaces for tick beats and result beats

interface pmc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [pmc_pkg::DeltaW-1:0]  encoder_delta;
  logic signed [pmc_pkg::CmdW-1:0]    position_command;

  modport source (output valid, output encoder_delta, output position_command, input ready);
  modport sink   (input valid, input encoder_delta, input position_command, output ready);
endinterface

interface pmc_out_if;
  logic                               valid;
  logic                               ready;
  logic                               direction;
  logic [pmc_pkg::SpeedW-1:0]         speed;
  logic signed [pmc_pkg::TposW-1:0]   tracked_position;

  modport source (output valid, output direction, output speed, output tracked_position,
                  input ready);
  modport sink   (input valid, input direction, input speed, input tracked_position,
                  output ready);
endinterface

// ===== rtl/pmc_law.sv =====
// pi control law: gain products, scaling toward zero and speed saturation
module pmc_law #(
  parameter int PosW = 13,
  parameter int ErrW = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pmc_pkg::pmc_ctl_t                 ctl_i,
  input  logic [pmc_pkg::GainW-1:0]         kp_i,
  input  logic [pmc_pkg::GainW-1:0]         ki_i,
  input  logic signed [ErrW-1:0]            err_i,
  input  logic signed [PosW-1:0]            esum_i,
  input  logic signed [PosW-1:0]            pos_i,
  output logic                              valid_o,
  output logic                              direction_o,
  output logic [pmc_pkg::SpeedW-1:0]        speed_o,
  output logic signed [pmc_pkg::TposW-1:0]  tracked_position_o
);

  localparam int PpW  = ErrW + pmc_pkg::GainW + 1;
  localparam int IpW  = PosW + pmc_pkg::GainW + 1;
  localparam int AccW = (PpW > IpW ? PpW : IpW) + 1;

  localparam logic signed [AccW-1:0] CtlRound = AccW'((1 << pmc_pkg::CtlShift) - 1);
  localparam logic signed [AccW-1:0] SatPos   = AccW'(pmc_pkg::SpeedMax);
  localparam logic signed [AccW-1:0] SatNeg   = AccW'(-pmc_pkg::SpeedMax);
  localparam logic signed [AccW-1:0] AccZero  = '0;

  logic signed [PpW-1:0]  pp_d, pp_q;
  logic signed [IpW-1:0]  ip_d, ip_q;
  logic signed [PosW-1:0] pos2_q;
  logic                   v2_q;

  logic signed [AccW-1:0]          acc, acc_adj, ctl, mag;
  logic                            dir_d, dir_q;
  logic [pmc_pkg::SpeedW-1:0]      speed_d, speed_q;
  logic signed [pmc_pkg::TposW-1:0] tpos_q;
  logic                            ov_q;

  // gain products
  assign pp_d = PpW'(signed'({1'b0, kp_i})) * PpW'(err_i);
  assign ip_d = IpW'(signed'({1'b0, ki_i})) * IpW'(esum_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      pp_q   <= pp_d;
      ip_q   <= ip_d;
      pos2_q <= pos_i;
    end
  end

  // sum, divide by 64 toward zero, split into direction and saturated speed
  always_comb begin
    acc     = AccW'(pp_q) + AccW'(ip_q);
    acc_adj = (acc < AccZero) ? (acc + CtlRound) : acc;
    ctl     = acc_adj >>> pmc_pkg::CtlShift;
    dir_d   = (ctl >= AccZero);
    mag     = dir_d ? ctl : -ctl;
    if ((ctl >= SatPos) || (ctl <= SatNeg)) begin
      speed_d = pmc_pkg::SpeedW'(pmc_pkg::SpeedMax);
    end else begin
      speed_d = mag[pmc_pkg::SpeedW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && v2_q) begin
      dir_q   <= dir_d;
      speed_q <= speed_d;
      tpos_q  <= pmc_pkg::TposW'(pos2_q);
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (ctl_i.adv) begin
      v2_q <= ctl_i.vld;
      ov_q <= v2_q;
    end
  end

  assign valid_o            = ov_q;
  assign direction_o        = dir_q;
  assign speed_o            = speed_q;
  assign tracked_position_o = tpos_q;

endmodule

// ===== rtl/position_pi_motor_controller_unit.sv =====
// Position PI motor controller. Each tick beat on in_i carries an encoder
// count delta and a signed position command; the block subtracts the delta
// from its kept position, clamps it to +/-POSITION_LIMIT, forms the error
// against command*32, adds error/32 (truncated toward zero) into an integral
// clamped to the same limit, and returns (kp*error + ki*integral)/64, also
// truncated toward zero, as a direction bit, a speed magnitude saturating at
// 255 and the tracked position (low 13 bits). A new tick is taken every
// cycle while the output is not stalled; a taken tick is stored in the
// state registers (updated position, integral and error), then in the
// gain product registers, then as the scaled and saturated result in the
// output register, where it is offered. The whole pipeline stalls
// only while a result waits at the output. Gains are written through the
// cfg port (index 0 proportional, index 1 integral, low 8 bits, reset 3)
// and must only change while no tick is in flight.
module position_pi_motor_controller_unit #(
  parameter int POSITION_LIMIT = 4000
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pmc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pmc_pkg::GainW-1:0]          cfg_wdata_i,
  pmc_in_if.sink                             in_i,
  pmc_out_if.source                          out_o
);

  localparam int PosW = $clog2(POSITION_LIMIT + 1) + 1;
  localparam int SumW = (PosW > pmc_pkg::DeltaW ? PosW : pmc_pkg::DeltaW) + 1;
  localparam int SetW = pmc_pkg::CmdW + pmc_pkg::SetShift;
  localparam int ErrW = (SetW > PosW ? SetW : PosW) + 1;
  localparam int IntW = (ErrW > PosW ? ErrW : PosW) + 1;

  localparam logic signed [SumW-1:0] PosHi    = SumW'(POSITION_LIMIT);
  localparam logic signed [SumW-1:0] PosLo    = SumW'(-POSITION_LIMIT);
  localparam logic signed [IntW-1:0] IntHi    = IntW'(POSITION_LIMIT);
  localparam logic signed [IntW-1:0] IntLo    = IntW'(-POSITION_LIMIT);
  localparam logic signed [ErrW-1:0] ErrRound = ErrW'((1 << pmc_pkg::SetShift) - 1);
  localparam logic signed [ErrW-1:0] ErrZero  = '0;

  logic [pmc_pkg::GainW-1:0] kp_q, ki_q;
  logic signed [PosW-1:0]    pos_d, pos_q;
  logic signed [PosW-1:0]    esum_d, esum_q;
  logic signed [ErrW-1:0]    err_d, err_q;
  logic                      v1_q;

  logic signed [SumW-1:0]    pos_raw;
  logic signed [SetW-1:0]    setpoint;
  logic signed [ErrW-1:0]    err_adj, err_div;
  logic signed [IntW-1:0]    esum_raw;

  pmc_pkg::pmc_ctl_t         ctl;
  logic                      accept;

  // gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= pmc_pkg::GainReset;
      ki_q <= pmc_pkg::GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pmc_pkg::RegPropGain: kp_q <= cfg_wdata_i;
        pmc_pkg::RegIntGain:  ki_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline advance: stall only when a finished beat is not taken
  assign ctl.adv     = !out_o.valid || out_o.ready;
  assign ctl.vld     = v1_q;
  assign in_i.ready  = ctl.adv;
  assign accept      = in_i.valid && ctl.adv;

  // position and integral update for one tick
  always_comb begin
    pos_raw = SumW'(pos_q) - SumW'(in_i.encoder_delta);
    if (pos_raw > PosHi) begin
      pos_d = PosW'(PosHi);
    end else if (pos_raw < PosLo) begin
      pos_d = PosW'(PosLo);
    end else begin
      pos_d = PosW'(pos_raw);
    end

    setpoint = SetW'(in_i.position_command) <<< pmc_pkg::SetShift;
    err_d    = ErrW'(setpoint) - ErrW'(pos_d);

    // error / 32 toward zero
    err_adj  = (err_d < ErrZero) ? (err_d + ErrRound) : err_d;
    err_div  = err_adj >>> pmc_pkg::SetShift;

    esum_raw = IntW'(esum_q) + IntW'(err_div);
    if (esum_raw > IntHi) begin
      esum_d = PosW'(IntHi);
    end else if (esum_raw < IntLo) begin
      esum_d = PosW'(IntLo);
    end else begin
      esum_d = PosW'(esum_raw);
    end
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      esum_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      esum_q <= esum_d;
    end
  end

  // error of the tick in flight
  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ctl.adv) begin
      v1_q <= in_i.valid;
    end
  end

  // control law and result register
  pmc_law #(
    .PosW (PosW),
    .ErrW (ErrW)
  ) u_law (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (ctl),
    .kp_i               (kp_q),
    .ki_i               (ki_q),
    .err_i              (err_q),
    .esum_i             (esum_q),
    .pos_i              (pos_q),
    .valid_o            (out_o.valid),
    .direction_o        (out_o.direction),
    .speed_o            (out_o.speed),
    .tracked_position_o (out_o.tracked_position)
  );

  // kept position stays within the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SumW'(pos_q) <= PosHi) && (SumW'(pos_q) >= PosLo))
    else $error("position left its clamp range");

  // integral stays within the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IntW'(esum_q) <= IntHi) && (IntW'(esum_q) >= IntLo))
    else $error("integral left its clamp range");

  // state moves only on a taken tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(pos_q) && $stable(esum_q))
    else $error("controller state changed without a tick");

  // a taken tick enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("taken tick lost at the first stage");

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the position pi motor controller: tick beats in, drive beats checked
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PosLimit  = 4000;
  localparam int IdleLimit = 300;
  localparam int DrainWait = 4;
  localparam int PhaseTicks = 72;

  // indexes past the register list, writes there must be ignored
  localparam logic [pmc_pkg::CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [pmc_pkg::CfgIdxW-1:0] RegSpareB = 2'd3;

  typedef struct packed {
    logic                              dir;
    logic [pmc_pkg::SpeedW-1:0]        speed;
    logic signed [pmc_pkg::TposW-1:0]  tpos;
  } drive_beat_t;

  typedef struct packed {
    logic signed [pmc_pkg::DeltaW-1:0] delta;
    logic signed [pmc_pkg::CmdW-1:0]   cmd;
    logic                              known;
    drive_beat_t                       drive;
  } tick_row_t;

  // directed ticks, starting from reset gains and cleared state
  localparam int NumRows = 22;
  localparam tick_row_t DirectedTicks [NumRows] = '{
    // nothing commanded, nothing moved
    '{16'sd0,       8'sd0,    1'b1, '{1'b1, 8'd0,   13'sd0}},
    // most negative delta and command: position pinned high, full reverse
    '{16'sh8000,    8'sh80,   1'b1, '{1'b0, 8'd255, 13'sd4000}},
    // most positive delta and command: position pinned low, full forward
    '{16'sd32767,   8'sd127,  1'b1, '{1'b1, 8'd255, -13'sd4000}},
    // small errors, truncation toward zero on both sides
    '{-16'sd3969,   8'sd0,    1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{-16'sd62,     8'sd0,    1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{16'sd31,      8'sd0,    1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{16'sd1,       8'sd1,    1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{-16'sd1,      -8'sd1,   1'b0, '{1'b0, 8'd0,   13'sd0}},
    // alternating bit patterns
    '{16'sh5555,    8'sh55,   1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{16'shAAAA,    8'shAA,   1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{16'sh7FFF,    8'sh00,   1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{16'shFFFF,    8'shFF,   1'b0, '{1'b0, 8'd0,   13'sd0}},
    // walk back toward the command
    '{16'sd100,     8'sd3,    1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{-16'sd200,    8'sd3,    1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{16'sd0,       8'sd3,    1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{16'sd0,       -8'sd64,  1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{-16'sd4000,   8'sd0,    1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{16'sd8000,    8'sd0,    1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{16'sd1000,    -8'sd100, 1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{-16'sd1,      8'sd127,  1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{16'sh4000,    8'sh40,   1'b0, '{1'b0, 8'd0,   13'sd0}},
    '{-16'sh4000,   -8'sh40,  1'b0, '{1'b0, 8'd0,   13'sd0}}
  };

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [pmc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [pmc_pkg::GainW-1:0]   cfg_wdata_i;

  pmc_in_if  tick_if ();
  pmc_out_if drive_if ();

  position_pi_motor_controller_unit #(
    .POSITION_LIMIT(PosLimit)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (tick_if),
    .out_o      (drive_if)
  );

  // shadow of the controller: gains, kept position and integral
  logic [pmc_pkg::GainW-1:0] kp_gain = pmc_pkg::GainReset;
  logic [pmc_pkg::GainW-1:0] ki_gain = pmc_pkg::GainReset;
  int                        kept_pos = 0;
  int                        integ_sum = 0;

  drive_beat_t pending_drive_q[$];
  int          mismatch_cnt = 0;
  bit          tick_rush = 1'b0;
  bit          drive_rush = 1'b0;
  int          burst_left = 0;
  bit          burst_up = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int clamp_to_limit(input int v);
    if (v < -PosLimit) return -PosLimit;
    if (v > PosLimit) return PosLimit;
    return v;
  endfunction

  // one control tick of the pi law, advancing the shadow state
  function automatic drive_beat_t pi_control_tick(
      input logic signed [pmc_pkg::DeltaW-1:0] delta,
      input logic signed [pmc_pkg::CmdW-1:0] cmd);
    int          err;
    longint      acc;
    longint      ctl;
    longint      mag;
    drive_beat_t res;
    kept_pos  = clamp_to_limit(kept_pos - int'(delta));
    err       = int'(cmd) * 32 - kept_pos;
    integ_sum = clamp_to_limit(integ_sum + err / 32);
    acc = longint'(kp_gain) * err + longint'(ki_gain) * integ_sum;
    ctl = acc / 64;
    mag = (ctl < 0) ? -ctl : ctl;
    if (mag > pmc_pkg::SpeedMax) mag = pmc_pkg::SpeedMax;
    res.dir   = (ctl >= 0);
    res.speed = mag[pmc_pkg::SpeedW-1:0];
    res.tpos  = kept_pos[pmc_pkg::TposW-1:0];
    return res;
  endfunction

  // register write, only issued while nothing is in flight
  task automatic write_gain(input logic [pmc_pkg::CfgIdxW-1:0] idx,
                            input logic [pmc_pkg::GainW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == pmc_pkg::RegPropGain) kp_gain = val;
    else if (idx == pmc_pkg::RegIntGain) ki_gain = val;
  endtask

  // drive one tick beat; valid stays high on return so back-to-back beats need no drop
  task automatic send_tick(input logic signed [pmc_pkg::DeltaW-1:0] delta,
                           input logic signed [pmc_pkg::CmdW-1:0] cmd,
                           input logic known, input drive_beat_t typed);
    int          gap;
    drive_beat_t predicted;
    if ($urandom_range(0, 29) == 0) tick_rush = !tick_rush;
    gap = tick_rush ? 0 : int'($urandom_range(0, 13));
    if (gap > 0) begin
      tick_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_if.valid            = 1'b1;
    tick_if.encoder_delta    = delta;
    tick_if.position_command = cmd;
    do @(posedge clk_i); while (!tick_if.ready);
    predicted = pi_control_tick(delta, cmd);
    pending_drive_q.push_back(known ? typed : predicted);
    @(negedge clk_i);
  endtask

  // random tick: raw noise, small tracking moves, or sustained pushes toward a clamp
  task automatic draw_tick(output logic signed [pmc_pkg::DeltaW-1:0] delta,
                           output logic signed [pmc_pkg::CmdW-1:0] cmd);
    int kind;
    int mag;
    int aim;
    kind = int'($urandom_range(0, 9));
    if (kind < 2) begin
      delta = pmc_pkg::DeltaW'($urandom());
      cmd   = pmc_pkg::CmdW'($urandom());
    end else if (kind < 5) begin
      delta = pmc_pkg::DeltaW'(int'($urandom_range(0, 128)) - 64);
      cmd   = pmc_pkg::CmdW'($urandom());
    end else begin
      if (burst_left == 0) begin
        burst_left = int'($urandom_range(15, 40));
        burst_up   = ($urandom_range(0, 1) != 0);
      end
      burst_left--;
      mag   = int'($urandom_range(100, 32767));
      aim   = int'($urandom_range(64, 127));
      delta = pmc_pkg::DeltaW'(burst_up ? -mag : mag);
      cmd   = pmc_pkg::CmdW'(burst_up ? -aim : aim);
    end
  endtask

  task automatic wait_drain();
    while (pending_drive_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  // drive beat sink with random stalls, checks each beat against the oldest prediction
  initial begin
    int          gap;
    drive_beat_t exp_drive;
    drive_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) drive_rush = !drive_rush;
      gap = drive_rush ? 0 : int'($urandom_range(0, 13));
      if (gap > 0) begin
        drive_if.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      drive_if.ready = 1'b1;
      do @(posedge clk_i); while (!drive_if.valid);
      if (pending_drive_q.size() == 0) begin
        $error("drive beat with no tick pending");
        mismatch_cnt++;
      end else begin
        exp_drive = pending_drive_q.pop_front();
        if (drive_if.direction !== exp_drive.dir) begin
          $error("direction: expected %0d, got %0d", exp_drive.dir, drive_if.direction);
          mismatch_cnt++;
        end
        if (drive_if.speed !== exp_drive.speed) begin
          $error("speed: expected %0d, got %0d", exp_drive.speed, drive_if.speed);
          mismatch_cnt++;
        end
        if (drive_if.tracked_position !== exp_drive.tpos) begin
          $error("tracked_position: expected %0d, got %0d", exp_drive.tpos,
                 drive_if.tracked_position);
          mismatch_cnt++;
        end
      end
      @(negedge clk_i);
    end
  end

  // watchdog on cycles where no beat moves on either channel
  initial begin
    int idle_cnt;
    idle_cnt = 0;
    forever begin
      @(posedge clk_i);
      if ((tick_if.valid && tick_if.ready) || (drive_if.valid && drive_if.ready)) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
      end
      if (idle_cnt >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // stimulus: directed table at reset gains, then random phases over several gain settings
  initial begin
    logic signed [pmc_pkg::DeltaW-1:0] delta;
    logic signed [pmc_pkg::CmdW-1:0]   cmd;
    logic [pmc_pkg::GainW-1:0]         kp_set [6];
    logic [pmc_pkg::GainW-1:0]         ki_set [6];
    drive_beat_t                       none;
    none                     = '0;
    rst_ni                   = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_idx_i                = pmc_pkg::RegPropGain;
    cfg_wdata_i              = '0;
    tick_if.valid            = 1'b0;
    tick_if.encoder_delta    = '0;
    tick_if.position_command = '0;
    kp_set = '{8'd0, 8'd255, 8'd255, 8'd0,
               pmc_pkg::GainW'($urandom()), pmc_pkg::GainW'($urandom())};
    ki_set = '{8'd0, 8'd255, 8'd0, 8'd255,
               pmc_pkg::GainW'($urandom()), pmc_pkg::GainW'($urandom())};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      send_tick(DirectedTicks[i].delta, DirectedTicks[i].cmd, DirectedTicks[i].known,
                DirectedTicks[i].drive);
    end
    tick_if.valid = 1'b0;
    wait_drain();

    for (int p = 0; p < 6; p++) begin
      write_gain(($urandom_range(0, 1) != 0) ? RegSpareA : RegSpareB,
                 pmc_pkg::GainW'($urandom()));
      write_gain(pmc_pkg::RegPropGain, kp_set[p]);
      write_gain(pmc_pkg::RegIntGain, ki_set[p]);
      for (int n = 0; n < PhaseTicks; n++) begin
        draw_tick(delta, cmd);
        send_tick(delta, cmd, 1'b0, none);
      end
      tick_if.valid = 1'b0;
      wait_drain();
    end

    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== position_pi_motor_controller_unit.f =====
rtl/pmc_pkg.sv
rtl/pmc_if.sv
rtl/pmc_law.sv
rtl/position_pi_motor_controller_unit.sv
bench/tb_top.sv
